/* src/insertion_sorter_with_shift_count_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the insertion sorter
// Concurrent check wrappers, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef INSERTION_SORTER_WITH_SHIFT_COUNT_DEFINES_SVH
`define INSERTION_SORTER_WITH_SHIFT_COUNT_DEFINES_SVH

`ifndef ASSERT_OFF
// Clocked check, quiet while reset is applied
`define ISWSC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// Clocked check, also active during reset
`define ISWSC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define ISWSC_ASSERT(label, prop, msg)
`define ISWSC_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

/* src/iswsc_pkg.sv */
// ----------------------------------------------------------------------------
// Insertion sorter package
// Shared sizes, control types and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package iswsc_pkg;

    localparam int CAPACITY  = 32;
    localparam int VALUE_W   = 32;
    localparam int COUNT_W   = 11;
    localparam int FILL_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int S_TDATA_W = ((VALUE_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((VALUE_W + COUNT_W + 7) / 8) * 8;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // control broadcast to every cell
    typedef struct packed {
        logic insert;      // compare against new value and open a slot
        logic shift_down;  // move contents one cell towards cell 0
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        ST_FILL,
        ST_SETTLE,
        ST_DRAIN
    } state_t;

endpackage

`default_nettype wire

/* src/iswsc_cell.sv */
// ----------------------------------------------------------------------------
// Sorter cell
// Holds one stored value; compares, takes from its lower neighbour on an
// insert and from its upper neighbour while draining.
// ----------------------------------------------------------------------------
`default_nettype none

module iswsc_cell import iswsc_pkg::*; (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire cell_ctrl_t                ctrl,
    input  wire logic signed [VALUE_W-1:0] new_value,
    input  wire logic                      lower_valid,
    input  wire logic                      lower_gt,
    input  wire logic signed [VALUE_W-1:0] lower_value,
    input  wire logic                      upper_valid,
    input  wire logic signed [VALUE_W-1:0] upper_value,
    output logic                           valid,
    output logic signed [VALUE_W-1:0]      value,
    output logic                           gt
);

    logic                      valid_reg, valid_next;
    logic signed [VALUE_W-1:0] value_reg, value_next;

    // an empty cell counts as greater, so the flags form a thermometer
    assign gt    = !valid_reg || (value_reg > new_value);
    assign valid = valid_reg;
    assign value = value_reg;

    always_comb begin
        valid_next = valid_reg;
        value_next = value_reg;
        if (ctrl.shift_down) begin
            valid_next = upper_valid;
            value_next = upper_value;
        end else if (ctrl.insert && gt) begin
            valid_next = valid_reg || lower_valid;
            value_next = lower_gt ? lower_value : new_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

endmodule

`default_nettype wire

/* src/iswsc_shift_ctr.sv */
// ----------------------------------------------------------------------------
// Shift counter
// Turns the cells' compare thermometer into the number of moved entries and
// accumulates it, saturating, from a registered copy of that number.
// ----------------------------------------------------------------------------
`default_nettype none

module iswsc_shift_ctr import iswsc_pkg::*; (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                insert,
    input  wire logic [CAPACITY-1:0] gt_vec,
    input  wire logic [FILL_W-1:0]   fill,
    input  wire logic                clear,
    output logic [COUNT_W-1:0]       shift_total
);

    logic [IDX_W-1:0]   first_idx;
    logic [FILL_W-1:0]  delta;
    logic [FILL_W-1:0]  delta_reg, delta_next;
    logic [COUNT_W:0]   sum;
    logic [COUNT_W-1:0] total_reg, total_next;

    // position of the lowest greater cell: edge detect, then OR-encode
    always_comb begin
        first_idx = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (gt_vec[i] && (i == 0 || !gt_vec[(i == 0) ? 0 : i - 1])) begin
                first_idx = first_idx | IDX_W'(i);
            end
        end
    end

    assign delta      = fill - FILL_W'(first_idx);
    assign delta_next = insert ? delta : '0;

    assign sum = {1'b0, total_reg} + (COUNT_W + 1)'(delta_reg);

    always_comb begin
        if (clear) begin
            total_next = '0;
        end else if (sum > {1'b0, COUNT_MAX}) begin
            total_next = COUNT_MAX;
        end else begin
            total_next = sum[COUNT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delta_reg <= '0;
            total_reg <= '0;
        end else begin
            delta_reg <= delta_next;
            total_reg <= total_next;
        end
    end

    assign shift_total = total_reg;

endmodule

`default_nettype wire

/* src/insertion_sorter_with_shift_count.sv */
// ----------------------------------------------------------------------------
// Insertion sorter with shift count
// Systolic row of compare-and-shift cells that sorts a set of signed values.
// ----------------------------------------------------------------------------
// Values arrive on the slave stream, one per transfer, and each is slotted
// into a row of CAPACITY cells kept in ascending order; a new value can
// be taken every clock while the set is being built. Every stored entry
// greater than the new one moves up a cell, and the number of such moves
// is accumulated (saturating) as the shift count; equal values keep arrival
// order. A value arriving when the row is full is dropped and the set is
// flagged as overflowed. The transfer with tlast set closes the set: after
// a settle state for the counter, the row empties through cell 0 at one
// result per cycle while the sink accepts them. Input is held off from the
// closing transfer until the last result is loaded into the output
// register; that register then still waits for the sink while the next set
// is accepted. Each result carries the set's shift count and overflow flag,
// and tlast marks the largest value of the set.
// ----------------------------------------------------------------------------
`default_nettype none

`include "insertion_sorter_with_shift_count_defines.svh"

module insertion_sorter_with_shift_count import iswsc_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // slave stream: values to sort
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // [31:0] value (signed)
    input  wire logic                 s_tlast,   // is_last
    // master stream: sorted results
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,   // [31:0] sorted_value, [42:32] shift_count
    output logic                      m_tlast,   // end_of_set
    output logic                      m_tuser    // overflowed
);

    // ---------------- state ----------------
    state_t            state_reg, state_next;
    logic [FILL_W-1:0] fill_level_reg, fill_level_next;
    logic              drop_flag_reg, drop_flag_next;

    logic                      m_tvalid_reg, m_tvalid_next;
    logic signed [VALUE_W-1:0] out_value_reg;
    logic [COUNT_W-1:0]        out_count_reg;
    logic                      out_end_reg;
    logic                      out_ovf_reg;

    // ---------------- control ----------------
    logic                      in_xfer;
    logic                      full;
    logic                      load_out;
    logic                      drain_done;
    cell_ctrl_t                ctrl;
    logic [COUNT_W-1:0]        shift_total;
    logic signed [VALUE_W-1:0] new_value;

    // cell chain wiring
    logic                      cell_valid [CAPACITY];
    logic signed [VALUE_W-1:0] cell_value [CAPACITY];
    logic                      cell_gt    [CAPACITY];
    logic [CAPACITY-1:0]       gt_vec;
    logic [CAPACITY-1:0]       valid_vec;

    assign new_value  = s_tdata[VALUE_W-1:0];
    assign in_xfer    = s_tvalid && s_tready;
    assign full       = (fill_level_reg == FILL_W'(CAPACITY));
    assign drain_done = load_out && (fill_level_reg == FILL_W'(1));

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_FILL: begin
                if (in_xfer && s_tlast) begin
                    state_next = ST_SETTLE;
                end
            end
            ST_SETTLE: begin
                state_next = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (drain_done) begin
                    state_next = ST_FILL;
                end
            end
            default: begin
                state_next = ST_FILL;
            end
        endcase
    end

    // state outputs
    always_comb begin
        s_tready        = 1'b0;
        load_out        = 1'b0;
        case (state_reg)
            ST_FILL: begin
                s_tready = 1'b1;
            end
            ST_DRAIN: begin
                load_out = !m_tvalid_reg || m_tready;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // broadcast to the row
    assign ctrl = '{insert: in_xfer && !full, shift_down: load_out};

    // fill level doubles as the drain counter
    always_comb begin
        fill_level_next = fill_level_reg;
        if (ctrl.insert) begin
            fill_level_next = fill_level_reg + FILL_W'(1);
        end else if (load_out) begin
            fill_level_next = fill_level_reg - FILL_W'(1);
        end
    end

    always_comb begin
        drop_flag_next = drop_flag_reg;
        if (drain_done) begin
            drop_flag_next = 1'b0;
        end else if (in_xfer && full) begin
            drop_flag_next = 1'b1;
        end
    end

    // output register: during the drain, loads while empty or while its transfer completes
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (load_out) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_FILL;
            fill_level_reg <= '0;
            drop_flag_reg  <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            fill_level_reg <= fill_level_next;
            drop_flag_reg  <= drop_flag_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_value_reg <= cell_value[0];
            out_count_reg <= shift_total;
            out_end_reg   <= (fill_level_reg == FILL_W'(1));
            out_ovf_reg   <= drop_flag_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(M_TDATA_W - VALUE_W - COUNT_W)'(0), out_count_reg, out_value_reg};
    assign m_tlast  = out_end_reg;
    assign m_tuser  = out_ovf_reg;

    // ---------------- cell chain ----------------
    // cell 0 sees a lower neighbour that is always valid and never greater
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic                      lo_valid;
        logic                      lo_gt;
        logic signed [VALUE_W-1:0] lo_value;
        logic                      up_valid;
        logic signed [VALUE_W-1:0] up_value;

        if (i == 0) begin : g_bottom
            assign lo_valid = 1'b1;
            assign lo_gt    = 1'b0;
            assign lo_value = '0;
        end else begin : g_lower
            assign lo_valid = cell_valid[i-1];
            assign lo_gt    = cell_gt[i-1];
            assign lo_value = cell_value[i-1];
        end

        if (i == CAPACITY - 1) begin : g_top
            assign up_valid = 1'b0;
            assign up_value = '0;
        end else begin : g_upper
            assign up_valid = cell_valid[i+1];
            assign up_value = cell_value[i+1];
        end

        iswsc_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .new_value   (new_value),
            .lower_valid (lo_valid),
            .lower_gt    (lo_gt),
            .lower_value (lo_value),
            .upper_valid (up_valid),
            .upper_value (up_value),
            .valid       (cell_valid[i]),
            .value       (cell_value[i]),
            .gt          (cell_gt[i])
        );

        assign gt_vec[i]    = cell_gt[i];
        assign valid_vec[i] = cell_valid[i];
    end

    iswsc_shift_ctr u_shift_ctr (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .insert      (ctrl.insert),
        .gt_vec      (gt_vec),
        .fill        (fill_level_reg),
        .clear       (drain_done),
        .shift_total (shift_total)
    );

    // ---------------- checks ----------------
    `ISWSC_ASSERT(a_fill_matches_cells, $countones(valid_vec) == fill_level_reg, "fill level disagrees with occupied cells")
    `ISWSC_ASSERT(a_drop_when_full, (in_xfer && full && !s_tlast) |=> drop_flag_reg, "value dropped on a full row without overflow flag")
    `ISWSC_ASSERT(a_settle_after_last, (in_xfer && s_tlast) |=> (state_reg == ST_SETTLE), "closing transfer did not start the settle cycle")
    `ISWSC_ASSERT(a_drain_not_empty, (state_reg == ST_DRAIN) |-> (fill_level_reg != '0), "draining an empty row")

endmodule

`default_nettype wire
